// ===== rtl/imuyaw_pkg.sv =====
// Package for the IMU frame yaw filter: frame constants, CORDIC constants and arctangent table.
`default_nettype none
package imuyaw_pkg;
	localparam int FRAME_BYTES = 11;
	localparam logic [7:0] HEADER_BYTE = 8'h55;
	localparam logic [7:0] ANGLE_TYPE = 8'h53;
	localparam int STEPS = 24;
	localparam int DW = 32;
	localparam int ZW = 34;
	localparam logic signed [DW-1:0] UNIT_GAIN = 32'sd636751;
	localparam logic signed [ZW-1:0] HALF_TURN = 34'sd2147483648;
	localparam logic signed [ZW-1:0] QUARTER_TURN = 34'sd1073741824;

	typedef logic signed [DW-1:0] data_t;
	typedef logic signed [ZW-1:0] angle_t;

	// arctan(2^-k) in turn units (full circle = 2^32)
	function automatic angle_t atan_turn(input logic [4:0] k);
		angle_t a;
		case (k)
			5'd0: a = 34'sd536870912;
			5'd1: a = 34'sd316933406;
			5'd2: a = 34'sd167458907;
			5'd3: a = 34'sd85004756;
			5'd4: a = 34'sd42667331;
			5'd5: a = 34'sd21354465;
			5'd6: a = 34'sd10679838;
			5'd7: a = 34'sd5340245;
			5'd8: a = 34'sd2670163;
			5'd9: a = 34'sd1335087;
			5'd10: a = 34'sd667544;
			5'd11: a = 34'sd333772;
			5'd12: a = 34'sd166886;
			5'd13: a = 34'sd83443;
			5'd14: a = 34'sd41722;
			5'd15: a = 34'sd20861;
			5'd16: a = 34'sd10430;
			5'd17: a = 34'sd5215;
			5'd18: a = 34'sd2608;
			5'd19: a = 34'sd1304;
			5'd20: a = 34'sd652;
			5'd21: a = 34'sd326;
			5'd22: a = 34'sd163;
			5'd23: a = 34'sd81;
			default: a = '0;
		endcase
		return a;
	endfunction
endpackage
`default_nettype wire

// ===== rtl/imu_frame_yaw_circular_mean.sv =====
// IMU serial frame parser with circular-mean yaw filter on a shared CORDIC unit.
//
// Slave stream: one received serial byte per beat in s_tdata.
// Master stream: one beat per completed 11-byte frame; m_tdata holds the
// filtered yaw in whole degrees, m_tuser the frame type byte.
// The parser hunts for a 0x55 header; other bytes at frame start are dropped.
// Header and body bytes are taken one per cycle. A non-angle frame emits its
// beat on the cycle after its last byte. An angle frame (type 0x53) runs the
// shared CORDIC stage: a zero check first, then for sine/cosine a load, 24
// rotations and an accumulate per ring entry (WINDOW entries), then a load
// and 24 rotations for vectoring, and a multiply and a clamp step for scaling.
// s_tready is low from the last byte until the result beat.
// The last byte of a frame is held off while a previous result beat still
// waits on m_tready; other bytes are still taken.
// Reset clears the parser, the ring, the held yaw and the output register.
`default_nettype none
module imu_frame_yaw_circular_mean #(
	parameter int WINDOW = 5
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // rx_byte[7:0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata,   // yaw_degrees[8:0], zero fill
	output logic [7:0]       m_tuser    // frame_type[7:0]
);
	import imuyaw_pkg::*;

	localparam int PW = $clog2(WINDOW);
	localparam logic [PW-1:0] LAST_SLOT = PW'(WINDOW - 1);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_CHK   = 3'd1;
	localparam logic [2:0] ST_LOAD  = 3'd2;
	localparam logic [2:0] ST_ROT   = 3'd3;
	localparam logic [2:0] ST_ACC   = 3'd4;
	localparam logic [2:0] ST_VLOAD = 3'd5;
	localparam logic [2:0] ST_VEC   = 3'd6;
	localparam logic [2:0] ST_DEG   = 3'd7;

	logic [2:0]          state_q;
	logic [3:0]          cnt_q;
	logic [7:0]          type_q, lo_q, hi_q;
	logic signed [15:0]  ring_q [WINDOW];
	logic [PW-1:0]       ptr_q, idx_q;
	logic [4:0]          k_q;
	logic                flip_q, vec_q, mul_q;
	data_t               x_q, y_q, sc_q, ss_q;
	angle_t              z_q;
	logic signed [8:0]   held_q;
	logic signed [42:0]  prod_q;

	logic accept, pos;
	data_t xs, ys, nx, ny;
	angle_t nz, t;
	logic signed [15:0] samp;
	logic signed [42:0] adj;
	logic signed [10:0] deg;
	logic signed [8:0] deg_c;

	assign s_tready = (state_q == ST_IDLE) && !(m_tvalid && cnt_q == 4'(FRAME_BYTES - 1));
	assign accept = s_tvalid && s_tready;

	// shared CORDIC step
	assign xs = x_q >>> k_q;
	assign ys = y_q >>> k_q;
	assign pos = vec_q ? !(y_q > 0) : (z_q >= 0);
	assign nx = pos ? x_q - ys : x_q + ys;
	assign ny = pos ? y_q + xs : y_q - xs;
	assign nz = pos ? z_q - atan_turn(k_q) : z_q + atan_turn(k_q);

	assign samp = ring_q[idx_q];
	assign t = {{2{samp[15]}}, samp, 16'b0};

	// truncate toward zero, then clamp
	assign adj = prod_q + (prod_q < 0 ? 43'sd4294967295 : 43'sd0);
	assign deg = adj[42:32];
	always_comb begin
		if (deg > 11'sd180) deg_c = 9'sd180;
		else if (deg < -11'sd180) deg_c = -9'sd180;
		else deg_c = deg[8:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			type_q <= '0;
			lo_q <= '0;
			hi_q <= '0;
			ptr_q <= '0;
			idx_q <= '0;
			k_q <= '0;
			flip_q <= 1'b0;
			vec_q <= 1'b0;
			mul_q <= 1'b0;
			x_q <= '0;
			y_q <= '0;
			z_q <= '0;
			sc_q <= '0;
			ss_q <= '0;
			prod_q <= '0;
			held_q <= '0;
			m_tvalid <= 1'b0;
			m_tdata <= '0;
			m_tuser <= '0;
			for (int i = 0; i < WINDOW; i++) ring_q[i] <= '0;
		end else begin
			if (m_tvalid && m_tready) m_tvalid <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept && !(cnt_q == 4'd0 && s_tdata != HEADER_BYTE)) begin
						case (cnt_q)
							4'd1: type_q <= s_tdata;
							4'd6: lo_q <= s_tdata;
							4'd7: hi_q <= s_tdata;
							default: ;
						endcase
						if (cnt_q == 4'(FRAME_BYTES - 1)) begin
							cnt_q <= '0;
							if (type_q == ANGLE_TYPE) begin
								ring_q[ptr_q] <= {hi_q, lo_q};
								ptr_q <= (ptr_q == LAST_SLOT) ? '0 : ptr_q + 1'b1;
								state_q <= ST_CHK;
							end else begin
								m_tvalid <= 1'b1;
								m_tdata <= {7'b0, held_q};
								m_tuser <= type_q;
							end
						end else begin
							cnt_q <= cnt_q + 1'b1;
						end
					end
				end
				ST_CHK: begin
					idx_q <= '0;
					sc_q <= '0;
					ss_q <= '0;
					if (ring_q[WINDOW-1] == 16'sd0) begin
						held_q <= '0;
						m_tvalid <= 1'b1;
						m_tdata <= '0;
						m_tuser <= type_q;
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					x_q <= UNIT_GAIN;
					y_q <= '0;
					k_q <= '0;
					vec_q <= 1'b0;
					if (t > QUARTER_TURN) begin
						z_q <= t - HALF_TURN;
						flip_q <= 1'b1;
					end else if (t < -QUARTER_TURN) begin
						z_q <= t + HALF_TURN;
						flip_q <= 1'b1;
					end else begin
						z_q <= t;
						flip_q <= 1'b0;
					end
					state_q <= ST_ROT;
				end
				ST_ROT, ST_VEC: begin
					x_q <= nx;
					y_q <= ny;
					z_q <= nz;
					k_q <= k_q + 1'b1;
					if (k_q == 5'(STEPS - 1)) begin
						state_q <= (state_q == ST_ROT) ? ST_ACC : ST_DEG;
						mul_q <= 1'b0;
					end
				end
				ST_ACC: begin
					sc_q <= flip_q ? sc_q - x_q : sc_q + x_q;
					ss_q <= flip_q ? ss_q - y_q : ss_q + y_q;
					if (idx_q == LAST_SLOT) begin
						state_q <= ST_VLOAD;
					end else begin
						idx_q <= idx_q + 1'b1;
						state_q <= ST_LOAD;
					end
				end
				ST_VLOAD: begin
					k_q <= '0;
					vec_q <= 1'b1;
					if (sc_q == 0 && ss_q == 0) begin
						held_q <= '0;
						m_tvalid <= 1'b1;
						m_tdata <= '0;
						m_tuser <= type_q;
						state_q <= ST_IDLE;
					end else begin
						if (sc_q < 0) begin
							x_q <= -sc_q;
							y_q <= -ss_q;
							z_q <= (ss_q >= 0) ? HALF_TURN : -HALF_TURN;
						end else begin
							x_q <= sc_q;
							y_q <= ss_q;
							z_q <= '0;
						end
						state_q <= ST_VEC;
					end
				end
				ST_DEG: begin
					if (!mul_q) begin
						prod_q <= 43'(z_q) * 43'sd360;
						mul_q <= 1'b1;
					end else begin
						held_q <= deg_c;
						m_tvalid <= 1'b1;
						m_tdata <= {7'b0, deg_c};
						m_tuser <= type_q;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ===== tb/tb_imu_frame_yaw_circular_mean.sv =====
// Testbench for the IMU frame parser with circular-mean yaw filter: table-driven and random byte streams.
`default_nettype none
module tb_imu_frame_yaw_circular_mean;
	timeunit 1ns;
	timeprecision 1ps;
	import imuyaw_pkg::*;

	localparam int WIN = 5;
	localparam int CYCLE_LIMIT = 2000000;
	localparam int RANDOM_BYTES = 1230;

	typedef struct {
		logic signed [8:0] yaw;
		logic [7:0]        ftype;
	} yaw_beat_t;

	typedef struct {
		logic [7:0]        rx;
		bit                typed;   // expected beat written out in the table
		logic signed [8:0] yaw;
		logic [7:0]        ftype;
	} stim_row_t;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        s_tvalid = 0;
	logic [7:0]  s_tdata = '0;
	logic        m_tready = 0;
	logic        s_tready;
	logic        m_tvalid;
	logic [15:0] m_tdata;
	logic [7:0]  m_tuser;

	imu_frame_yaw_circular_mean #(.WINDOW(WIN)) i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	always #2 clk = ~clk;

	// parser and filter state of the predictor
	int                 frame_pos;
	logic [7:0]         type_byte, yaw_lo, yaw_hi;
	logic signed [15:0] yaw_window [WIN];
	int                 wr_slot;
	logic signed [8:0]  yaw_hold;

	yaw_beat_t pending_yaw_beats[$];
	int  errors = 0;
	int  frames_seen = 0, angle_frames = 0, dropped_bytes = 0, beats_checked = 0;
	bit  sending_done = 0;
	int  bytes_sent = 0;
	longint cycles = 0;

	const longint atan_tab [STEPS] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772,
		166886, 83443, 41722, 20861, 10430, 5215,
		2608, 1304, 652, 326, 163, 81};

	function automatic void rotate_sample(input logic signed [15:0] smp,
			output longint c, output longint s);
		longint z, x, y, nx, ny;
		bit flip;
		z = longint'(smp) * 65536;
		x = 636751;
		y = 0;
		flip = 0;
		if (z > 64'sd1073741824) begin
			z -= 64'sd2147483648;
			flip = 1;
		end else if (z < -64'sd1073741824) begin
			z += 64'sd2147483648;
			flip = 1;
		end
		for (int k = 0; k < STEPS; k++) begin
			if (z >= 0) begin
				nx = x - (y >>> k);
				ny = y + (x >>> k);
				z -= atan_tab[k];
			end else begin
				nx = x + (y >>> k);
				ny = y - (x >>> k);
				z += atan_tab[k];
			end
			x = nx;
			y = ny;
		end
		c = flip ? -x : x;
		s = flip ? -y : y;
	endfunction

	function automatic logic signed [8:0] heading_of(input longint c, input longint s);
		longint x, y, z, nx, ny, deg;
		if (c == 0 && s == 0)
			return '0;
		x = c;
		y = s;
		z = 0;
		if (c < 0) begin
			x = -c;
			y = -s;
			z = (s >= 0) ? 64'sd2147483648 : -64'sd2147483648;
		end
		for (int k = 0; k < STEPS; k++) begin
			if (y > 0) begin
				nx = x + (y >>> k);
				ny = y - (x >>> k);
				z += atan_tab[k];
			end else begin
				nx = x - (y >>> k);
				ny = y + (x >>> k);
				z -= atan_tab[k];
			end
			x = nx;
			y = ny;
		end
		deg = (z * 360) / 64'sd4294967296;
		if (deg > 180) deg = 180;
		if (deg < -180) deg = -180;
		return deg[8:0];
	endfunction

	function automatic void refilter_yaw();
		longint sc, ss, c, s;
		yaw_window[wr_slot] = {yaw_hi, yaw_lo};
		wr_slot = (wr_slot + 1 >= WIN) ? 0 : wr_slot + 1;
		if (yaw_window[WIN-1] == 0) begin
			yaw_hold = '0;
			return;
		end
		sc = 0;
		ss = 0;
		for (int k = 0; k < WIN; k++) begin
			rotate_sample(yaw_window[k], c, s);
			sc += c;
			ss += s;
		end
		yaw_hold = heading_of(sc, ss);
	endfunction

	// feed one accepted byte; returns 1 and the beat when a frame completes
	function automatic bit parse_byte(input logic [7:0] b, output yaw_beat_t beat);
		beat.yaw = '0;
		beat.ftype = '0;
		if (frame_pos == 0 && b != HEADER_BYTE) begin
			dropped_bytes++;
			return 0;
		end
		case (frame_pos)
			1: type_byte = b;
			6: yaw_lo = b;
			7: yaw_hi = b;
			default: ;
		endcase
		frame_pos++;
		if (frame_pos < FRAME_BYTES)
			return 0;
		frame_pos = 0;
		frames_seen++;
		if (type_byte == ANGLE_TYPE) begin
			angle_frames++;
			refilter_yaw();
		end
		beat.yaw = yaw_hold;
		beat.ftype = type_byte;
		return 1;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(3, 1);
		return $urandom_range(40, 10);
	endfunction

	bit quiet_sender = 0;

	task automatic send_byte(input logic [7:0] b, input bit typed = 0,
			input logic signed [8:0] t_yaw = '0, input logic [7:0] t_type = '0);
		int gap;
		yaw_beat_t beat;
		gap = quiet_sender ? 0 : pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			s_tvalid <= 0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid <= 1;
		s_tdata <= b;
		do @(posedge clk); while (!s_tready);
		bytes_sent++;
		if (parse_byte(b, beat)) begin
			if (typed && (beat.yaw !== t_yaw || beat.ftype !== t_type)) begin
				$error("table row disagrees: yaw exp %0d got %0d, type exp %02h got %02h",
					t_yaw, beat.yaw, t_type, beat.ftype);
				errors++;
			end
			pending_yaw_beats.push_back(beat);
		end
	endtask

	task automatic send_frame(input logic [7:0] ftype, input logic [15:0] yaw);
		send_byte(HEADER_BYTE);
		send_byte(ftype);
		for (int k = 2; k < FRAME_BYTES; k++)
			send_byte(k == 6 ? yaw[7:0] : k == 7 ? yaw[15:8] : 8'($urandom));
	endtask

	function automatic logic [15:0] pick_yaw();
		logic [15:0] edge_vals [7] = '{16'h0000, 16'h7FFF, 16'h8000, 16'h0001,
			16'hFFFF, 16'h4000, 16'hC000};
		if ($urandom_range(3) == 0)
			return edge_vals[$urandom_range(6)];
		return 16'($urandom);
	endfunction

	// directed rows: stray bytes before sync, a full non-angle frame, then
	// an angle frame while the last ring slot is still zero
	stim_row_t stim_table [] = '{
		'{8'h00, 0, 0, 0}, '{8'hFF, 0, 0, 0}, '{8'h53, 0, 0, 0},
		'{8'h55, 0, 0, 0}, '{8'hFF, 0, 0, 0}, '{8'hFF, 0, 0, 0},
		'{8'h00, 0, 0, 0}, '{8'hFF, 0, 0, 0}, '{8'h00, 0, 0, 0},
		'{8'hFF, 0, 0, 0}, '{8'h00, 0, 0, 0}, '{8'hFF, 0, 0, 0},
		'{8'h00, 0, 0, 0}, '{8'h55, 1, 9'sd0, 8'hFF},
		'{8'h55, 0, 0, 0}, '{8'h53, 0, 0, 0}, '{8'h00, 0, 0, 0},
		'{8'h00, 0, 0, 0}, '{8'h00, 0, 0, 0}, '{8'h00, 0, 0, 0},
		'{8'hFF, 0, 0, 0}, '{8'h7F, 0, 0, 0}, '{8'h00, 0, 0, 0},
		'{8'h00, 0, 0, 0}, '{8'h00, 1, 9'sd0, 8'h53}
	};

	// stimulus
	initial begin
		int left;
		frame_pos = 0;
		type_byte = '0;
		yaw_lo = '0;
		yaw_hi = '0;
		wr_slot = 0;
		yaw_hold = '0;
		foreach (yaw_window[k]) yaw_window[k] = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;
		foreach (stim_table[k])
			send_byte(stim_table[k].rx, stim_table[k].typed, stim_table[k].yaw,
				stim_table[k].ftype);
		left = RANDOM_BYTES;
		while (left > 0) begin
			quiet_sender = ($urandom_range(4) == 0);
			if ($urandom_range(99) < 85) begin
				send_frame($urandom_range(9) < 7 ? ANGLE_TYPE : 8'($urandom), pick_yaw());
				left -= FRAME_BYTES;
			end else begin
				// noise and cut-off frames
				for (int n = $urandom_range(12, 1); n > 0; n--) begin
					send_byte($urandom_range(2) == 0 ? HEADER_BYTE : 8'($urandom));
					left--;
				end
			end
		end
		@(negedge clk);
		s_tvalid <= 0;
		sending_done = 1;
	end

	// result side ready, with one long hold-off once traffic is under way
	initial begin
		int gap;
		bit held_off;
		held_off = 0;
		forever begin
			@(negedge clk);
			if (!held_off && bytes_sent > 300) begin
				held_off = 1;
				m_tready <= 0;
				for (int n = 0; n < 800; n++) @(negedge clk);
			end
			gap = ($urandom_range(4) == 0) ? pick_gap() : 0;
			if (gap > 0) begin
				m_tready <= 0;
				repeat (gap) @(negedge clk);
			end
			m_tready <= 1;
		end
	end

	// result checking
	always @(posedge clk) begin
		yaw_beat_t exp_beat;
		cycles++;
		if (m_tvalid && m_tready) begin
			if (pending_yaw_beats.size() == 0) begin
				$error("unexpected beat: yaw %0d type %02h", $signed(m_tdata[8:0]), m_tuser);
				errors++;
			end else begin
				exp_beat = pending_yaw_beats.pop_front();
				beats_checked++;
				if (m_tdata[8:0] !== exp_beat.yaw) begin
					$error("yaw_degrees: expected %0d, got %0d", exp_beat.yaw,
						$signed(m_tdata[8:0]));
					errors++;
				end
				if (m_tuser !== exp_beat.ftype) begin
					$error("frame_type: expected %02h, got %02h", exp_beat.ftype, m_tuser);
					errors++;
				end
			end
		end
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d beats outstanding", cycles,
				pending_yaw_beats.size());
			$display("** imu_frame_yaw_circular_mean: FAILED **");
			$finish;
		end
	end

	initial begin
		wait (sending_done && pending_yaw_beats.size() == 0);
		repeat (200) @(posedge clk);
		if (pending_yaw_beats.size() != 0) begin
			$error("%0d expected beats never arrived", pending_yaw_beats.size());
			errors++;
		end
		$display("sent %0d bytes: %0d frames (%0d angle), %0d bytes dropped before sync",
			bytes_sent, frames_seen, angle_frames, dropped_bytes);
		$display("checked %0d result beats, %0d mismatches", beats_checked, errors);
		if (errors == 0)
			$display("** imu_frame_yaw_circular_mean: PASSED **");
		else
			$display("** imu_frame_yaw_circular_mean: FAILED **");
		$finish;
	end
endmodule
`default_nettype wire

// ===== sim.f =====
rtl/imuyaw_pkg.sv
rtl/imu_frame_yaw_circular_mean.sv
tb/tb_imu_frame_yaw_circular_mean.sv
